[hdl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// Seven-segment driver package
// Shared types, action codes and glyph tables for the display driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned DigitCount = 4;
  localparam int unsigned SegWidth   = 8;
  localparam int unsigned ValueWidth = 14;

  localparam logic [15:0] MaxValue = 16'd9999;

  // Reciprocal multipliers for division by 1000, 100 and 10 of values up to 9999.
  localparam logic [26:0] Recip1000 = 27'd8389;
  localparam logic [25:0] Recip100  = 26'd5243;
  localparam logic [28:0] Recip10   = 29'd52429;

  typedef enum logic [1:0] {
    ACT_REFRESH = 2'd0,
    ACT_NUMBER  = 2'd1,
    ACT_TEXT    = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef logic [DigitCount-1:0][SegWidth-1:0] seg_row_t;

  typedef struct packed {
    logic [1:0]                         action;
    logic [15:0]                        number_value;
    logic [DigitCount-1:0][7:0]         chars;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] action;
    seg_row_t   segs;
  } enc_t;

  function automatic logic [SegWidth-1:0] digit_glyph(input logic [3:0] d);
    logic [SegWidth-1:0] g;
    begin
      case (d)
        4'd0:    g = 8'h3F;
        4'd1:    g = 8'h06;
        4'd2:    g = 8'h5B;
        4'd3:    g = 8'h4F;
        4'd4:    g = 8'h66;
        4'd5:    g = 8'h6D;
        4'd6:    g = 8'h7D;
        4'd7:    g = 8'h07;
        4'd8:    g = 8'h7F;
        4'd9:    g = 8'h6F;
        default: g = 8'h00;
      endcase
      return g;
    end
  endfunction

  function automatic logic [SegWidth-1:0] char_glyph(input logic [7:0] c);
    logic [SegWidth-1:0] g;
    begin
      case (c) inside
        [8'h30:8'h39]: g = digit_glyph(c[3:0]);
        8'h41:   g = 8'h77;  // A
        8'h62:   g = 8'h7C;  // b
        8'h43:   g = 8'h39;  // C
        8'h64:   g = 8'h5E;  // d
        8'h45:   g = 8'h79;  // E
        8'h46:   g = 8'h71;  // F
        8'h47:   g = 8'h3D;  // G
        8'h48:   g = 8'h76;  // H
        8'h49:   g = 8'h06;  // I
        8'h4C:   g = 8'h38;  // L
        8'h6E:   g = 8'h54;  // n
        8'h4F:   g = 8'h3F;  // O
        8'h6F:   g = 8'h5C;  // o
        8'h50:   g = 8'h73;  // P
        8'h72:   g = 8'h50;  // r
        8'h55:   g = 8'h3E;  // U
        8'h2D:   g = 8'h40;  // -
        default: g = 8'h00;
      endcase
      return g;
    end
  endfunction

endpackage

[hdl/ssd_if.sv]
// ----------------------------------------------------------------------------
// Seven-segment driver channels
// Valid/ready channels for items, results and the configuration register.
// ----------------------------------------------------------------------------
interface ssd_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [15:0] number_value;
  logic [7:0] char_first;
  logic [7:0] char_second;
  logic [7:0] char_third;
  logic [7:0] char_fourth;

  modport source (
    output valid, action, number_value, char_first, char_second, char_third, char_fourth,
    input  ready
  );
  modport sink (
    input  valid, action, number_value, char_first, char_second, char_third, char_fourth,
    output ready
  );
endinterface

interface ssd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] segment_lines;
  logic [1:0] digit_select;

  modport source (output valid, segment_lines, digit_select, input ready);
  modport sink (input valid, segment_lines, digit_select, output ready);
endinterface

interface ssd_cfg_if;
  logic valid;
  logic ready;
  logic segments_active_low;

  modport source (output valid, segments_active_low, input ready);
  modport sink (input valid, segments_active_low, output ready);
endinterface

[hdl/ssd_encode.sv]
// ----------------------------------------------------------------------------
// Seven-segment encoder
// Turns a number or four characters into four segment bytes over one stage.
// ----------------------------------------------------------------------------
module ssd_encode (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          in_valid,
  input  ssd_pkg::item_t item,
  output ssd_pkg::enc_t  enc
);

  logic [ssd_pkg::ValueWidth-1:0] sat_value;
  logic [26:0] prod1000;
  logic [25:0] prod100;
  logic [28:0] prod10;

  logic                           valid;
  logic [1:0]                     action;
  logic [ssd_pkg::ValueWidth-1:0] value;
  logic [3:0]                     q1000;
  logic [6:0]                     q100;
  logic [9:0]                     q10;
  ssd_pkg::seg_row_t              text_segs;

  logic [6:0]  rem2;
  logic [9:0]  rem1;
  logic [13:0] rem0;
  logic [3:0]  d3, d2, d1, d0;
  ssd_pkg::seg_row_t num_segs;

  assign sat_value = (item.number_value > ssd_pkg::MaxValue) ?
                     ssd_pkg::MaxValue[ssd_pkg::ValueWidth-1:0] :
                     item.number_value[ssd_pkg::ValueWidth-1:0];

  assign prod1000 = 27'(sat_value) * ssd_pkg::Recip1000;
  assign prod100  = 26'(sat_value) * ssd_pkg::Recip100;
  assign prod10   = 29'(sat_value) * ssd_pkg::Recip10;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= in_valid;
    end
    if (advance) begin
      action <= item.action;
      value  <= sat_value;
      q1000  <= prod1000[26:23];
      q100   <= prod100[25:19];
      q10    <= prod10[28:19];
      for (int i = 0; i < ssd_pkg::DigitCount; i++) begin
        text_segs[i] <= ssd_pkg::char_glyph(item.chars[i]);
      end
    end
  end

  // Each digit below the thousands is the quotient at its weight less ten times the next larger quotient.
  assign rem2 = q100 - {q1000, 3'b000} - {2'b00, q1000, 1'b0};
  assign rem1 = q10 - {q100, 3'b000} - {2'b00, q100, 1'b0};
  assign rem0 = value - {1'b0, q10, 3'b000} - {3'b000, q10, 1'b0};

  assign d3 = q1000;
  assign d2 = rem2[3:0];
  assign d1 = rem1[3:0];
  assign d0 = rem0[3:0];

  always_comb begin
    num_segs[0] = (d3 != 4'd0) ? ssd_pkg::digit_glyph(d3) : '0;
    num_segs[1] = (d3 != 4'd0 || d2 != 4'd0) ? ssd_pkg::digit_glyph(d2) : '0;
    num_segs[2] = (d3 != 4'd0 || d2 != 4'd0 || d1 != 4'd0) ?
                  ssd_pkg::digit_glyph(d1) : '0;
    num_segs[3] = ssd_pkg::digit_glyph(d0);
  end

  always_comb begin
    enc.valid  = valid;
    enc.action = action;
    case (action)
      ssd_pkg::ACT_NUMBER: enc.segs = num_segs;
      ssd_pkg::ACT_TEXT:   enc.segs = text_segs;
      default:             enc.segs = '0;
    endcase
  end

endmodule

[hdl/seven_segment_display_driver.sv]
// ----------------------------------------------------------------------------
// Seven-segment display driver
// Four-digit multiplexed seven-segment driver with number and text writes.
// ----------------------------------------------------------------------------
// The item channel carries an action: a refresh tick, a number write or a
// four-character text write. Writes update the four-byte segment buffer and
// produce nothing on the result channel. Each refresh tick produces one
// result with the bit-reversed pattern of the digit at the scan position and
// its two-bit select code, then moves the scan position on by one.
// The configuration channel writes the active-low flag, which inverts the
// segment lines; it is always ready and should only be written while idle.
// An item goes through an input register, an encode register and the result
// register before its result is offered. The pipeline takes one item per
// cycle while the result channel is not stalled. When the receiver holds
// ready low with a result pending, the whole pipeline holds and item ready
// drops in the same cycle. Reset blanks the buffer, clears the scan position
// and flag, and empties the pipeline.
// ----------------------------------------------------------------------------
module seven_segment_display_driver (
  input  logic               clk,
  input  logic               rst,
  ssd_item_if.sink           item,
  ssd_result_if.source       result,
  ssd_cfg_if.sink            cfg
);

  logic              advance;
  logic              s1_valid;
  ssd_pkg::item_t    s1_item;
  ssd_pkg::enc_t     enc;

  ssd_pkg::seg_row_t segment_buffer;
  logic [1:0]        scan_position;
  logic              active_low;

  logic              result_valid;
  logic [7:0]        segment_lines;
  logic [1:0]        digit_select;
  logic [7:0]        lines_rev;
  logic [7:0]        lines_next;

  assign advance    = !result_valid || result.ready;
  assign item.ready = advance;
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= item.valid;
    end
    if (advance) begin
      s1_item.action       <= item.action;
      s1_item.number_value <= item.number_value;
      s1_item.chars[0]     <= item.char_first;
      s1_item.chars[1]     <= item.char_second;
      s1_item.chars[2]     <= item.char_third;
      s1_item.chars[3]     <= item.char_fourth;
    end
  end

  ssd_encode u_encode (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s1_valid),
    .item     (s1_item),
    .enc      (enc)
  );

  assign lines_rev  = {<<{segment_buffer[scan_position]}};
  assign lines_next = lines_rev ^ {8{active_low}};

  always_ff @(posedge clk) begin
    if (rst) begin
      active_low     <= 1'b0;
      segment_buffer <= '0;
      scan_position  <= 2'd0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        active_low <= cfg.segments_active_low;
      end
      if (advance) begin
        result_valid <= 1'b0;
        if (enc.valid) begin
          case (enc.action)
            ssd_pkg::ACT_REFRESH: begin
              result_valid  <= 1'b1;
              segment_lines <= lines_next;
              digit_select  <= scan_position;
              scan_position <= scan_position + 2'd1;
            end
            ssd_pkg::ACT_NUMBER, ssd_pkg::ACT_TEXT: begin
              segment_buffer <= enc.segs;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign result.valid         = result_valid;
  assign result.segment_lines = segment_lines;
  assign result.digit_select  = digit_select;

endmodule
